@@ rtl/sphk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphk_pkg: shared types and constants for the SPH kernel shape evaluator
// Q.30 datapath widths, kernel mode codes, lane and side-band types.
// ----------------------------------------------------------------------------
package sphk_pkg;

    localparam int IB            = 30;
    localparam int W_Q           = IB + 1;
    localparam int W_CNT         = 3;
    localparam int N_LANES       = 3;
    localparam int N_CELLS       = 7;
    localparam int W_POLY        = IB + 7;
    localparam int W_SUM         = IB + 6;
    localparam int W_WT          = IB + 10;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [W_Q-1:0] Q_ONE  = W_Q'(1) << IB;
    localparam logic [W_Q-1:0] Q_HALF = W_Q'(1) << (IB - 1);

    typedef enum logic [2:0] {
        MODE_CUBIC   = 3'd0,
        MODE_QUARTIC = 3'd1,
        MODE_QUINTIC = 3'd2,
        MODE_WC2     = 3'd3,
        MODE_WC4     = 3'd4,
        MODE_WC6     = 3'd5
    } t_mode;

    // one power chain: base x, running power r, multiplies still to do
    typedef struct packed {
        logic [W_Q-1:0]   x;
        logic [W_Q-1:0]   r;
        logic [W_CNT-1:0] cnt;
    } t_lane;

    typedef struct packed {
        logic [2:0]     mode;
        logic [W_Q-1:0] q;
    } t_side;

    function automatic t_lane lane_init(input logic [W_Q-1:0] x, input logic [W_CNT-1:0] n);
        t_lane l;
        l.x   = x;
        l.r   = x;
        l.cnt = n;
        return l;
    endfunction

endpackage

@@ rtl/sph_kernel_shape_evaluator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sph_kernel_shape_evaluator_unit: SPH smoothing-kernel shape evaluator
// Spline and Wendland kernel shapes over q in [0,1), Q1.FRAC_BITS result.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                  | payload
//  in      | in  | i_in_valid / o_in_stall    | i_dist_q, i_mode
//  out     | out | o_out_valid / i_out_stall  | o_weight
//
//  One item per cycle unless i_out_stall backs up the pipeline; 12 stages.
//  The stages are the 7-cell multiply chain (eighth power of 1-q) plus
//  setup, three assembly stages and the output register.
//  Reset clears only the stage valid bits; the input stalls during reset.
//  Stages advance independently: empty stages fill while the output stalls,
//  and o_in_stall rises only once every stage holds an item.
// ----------------------------------------------------------------------------
module sph_kernel_shape_evaluator_unit #(
    parameter int FRAC_BITS = sphk_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [FRAC_BITS-1:0] i_dist_q,
    input  logic [2:0]           i_mode,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [FRAC_BITS:0]   o_weight
);
    import sphk_pkg::*;

    localparam int SH     = IB - FRAC_BITS;
    localparam int NSTG   = N_CELLS + 5;
    localparam int ST_T   = N_CELLS + 1;
    localparam int ST_OUT = NSTG - 1;
    localparam logic [W_WT-1:0] ONE_OUT = W_WT'(1) << FRAC_BITS;

    logic [NSTG-1:0]     r_v;
    logic [NSTG-1:0]     n_v;
    logic [NSTG-1:0]     en;
    logic                in_acc;
    logic                out_acc;

    t_lane [N_LANES-1:0] c_lane [N_CELLS+1];
    t_side               c_side [N_CELLS+1];

    logic signed [W_WT-1:0] t_w;
    logic [W_WT-1:0]        w_pos;
    logic [W_WT-1:0]        w_rnd;
    logic [FRAC_BITS:0]     n_weight;
    logic [FRAC_BITS:0]     r_weight;

    always_comb begin
        en[ST_OUT] = !r_v[ST_OUT] || !i_out_stall;
        for (int s = ST_OUT - 1; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
        n_v = r_v;
        for (int s = 0; s < NSTG; s++) begin
            if (en[s]) begin
                n_v[s] = (s == 0) ? i_in_valid : r_v[(s == 0) ? 0 : s - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_in_stall  = !en[0] || !i_rst_n;
    assign o_out_valid = r_v[ST_OUT];
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;

    sphk_setup #(
        .FRAC_BITS (FRAC_BITS)
    ) u_setup (
        .i_clk    (i_clk),
        .i_en     (en[0]),
        .i_dist_q (i_dist_q),
        .i_mode   (i_mode),
        .o_lane   (c_lane[0]),
        .o_side   (c_side[0])
    );

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        sphk_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en[k+1]),
            .i_lane (c_lane[k]),
            .i_side (c_side[k]),
            .o_lane (c_lane[k+1]),
            .o_side (c_side[k+1])
        );
    end

    sphk_tail u_tail (
        .i_clk  (i_clk),
        .i_en   (en[ST_T +: 3]),
        .i_lane (c_lane[N_CELLS]),
        .i_side (c_side[N_CELLS]),
        .o_w    (t_w)
    );

    assign w_pos = t_w[W_WT-1] ? '0 : W_WT'(t_w);

    if (SH > 0) begin : g_rnd
        assign w_rnd = (w_pos + (W_WT'(1) << (SH - 1))) >> SH;
    end else begin : g_nornd
        assign w_rnd = w_pos;
    end

    always_comb begin
        if (w_rnd > ONE_OUT) begin
            n_weight = ONE_OUT[FRAC_BITS:0];
        end else begin
            n_weight = w_rnd[FRAC_BITS:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_weight <= n_weight;
        end
    end

    assign o_weight = r_weight;

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> $countones(r_v) ==
            $past($countones(r_v)) + int'($past(in_acc)) - int'($past(out_acc)))
        else $error("stage occupancy does not track accepted and delivered items");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_v) && i_out_stall)
        else $error("input stalled while a stage is empty");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_weight <= ONE_OUT[FRAC_BITS:0])
        else $error("weight above 1.0");

endmodule

@@ rtl/sphk_setup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphk_setup: lane setup stage
// Forms q, 1-q and the spline breakpoint terms and loads the power lanes.
// ----------------------------------------------------------------------------
module sphk_setup #(
    parameter int FRAC_BITS = sphk_pkg::FRAC_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_en,
    input  logic [FRAC_BITS-1:0]                     i_dist_q,
    input  logic [2:0]                               i_mode,
    output sphk_pkg::t_lane [sphk_pkg::N_LANES-1:0]  o_lane,
    output sphk_pkg::t_side                          o_side
);
    import sphk_pkg::*;

    localparam int SH = IB - FRAC_BITS;

    // breakpoint c = num/den: K = round(c * 2^IB), T = ceil(c * 2^IB)
    localparam logic [63:0] K35_F = ((64'd3 << IB) + 64'd2) / 64'd5;
    localparam logic [63:0] T35_F = ((64'd3 << IB) + 64'd4) / 64'd5;
    localparam logic [63:0] K15_F = ((64'd1 << IB) + 64'd2) / 64'd5;
    localparam logic [63:0] T15_F = ((64'd1 << IB) + 64'd4) / 64'd5;
    localparam logic [63:0] K23_F = ((64'd2 << IB) + 64'd1) / 64'd3;
    localparam logic [63:0] T23_F = ((64'd2 << IB) + 64'd2) / 64'd3;
    localparam logic [63:0] K13_F = ((64'd1 << IB) + 64'd1) / 64'd3;
    localparam logic [63:0] T13_F = ((64'd1 << IB) + 64'd2) / 64'd3;

    localparam logic [W_Q-1:0] K35 = K35_F[W_Q-1:0];
    localparam logic [W_Q-1:0] T35 = T35_F[W_Q-1:0];
    localparam logic [W_Q-1:0] K15 = K15_F[W_Q-1:0];
    localparam logic [W_Q-1:0] T15 = T15_F[W_Q-1:0];
    localparam logic [W_Q-1:0] K23 = K23_F[W_Q-1:0];
    localparam logic [W_Q-1:0] T23 = T23_F[W_Q-1:0];
    localparam logic [W_Q-1:0] K13 = K13_F[W_Q-1:0];
    localparam logic [W_Q-1:0] T13 = T13_F[W_Q-1:0];

    logic [W_Q-1:0]             q;
    logic [W_Q-1:0]             omq;
    t_lane [N_LANES-1:0]        n_lane;
    t_lane [N_LANES-1:0]        r_lane;
    t_side                      r_side;

    always_comb begin
        q      = W_Q'(i_dist_q) << SH;
        omq    = Q_ONE - q;
        n_lane = '0;
        unique case (t_mode'(i_mode))
            MODE_CUBIC: begin
                n_lane[0] = lane_init(omq, W_CNT'(2));
                if (q < Q_HALF) begin
                    n_lane[1] = lane_init(Q_HALF - q, W_CNT'(2));
                end
            end
            MODE_QUARTIC: begin
                n_lane[0] = lane_init(omq, W_CNT'(3));
                if (q < T35) begin
                    n_lane[1] = lane_init(K35 - q, W_CNT'(3));
                end
                if (q < T15) begin
                    n_lane[2] = lane_init(K15 - q, W_CNT'(3));
                end
            end
            MODE_QUINTIC: begin
                n_lane[0] = lane_init(omq, W_CNT'(4));
                if (q < T23) begin
                    n_lane[1] = lane_init(K23 - q, W_CNT'(4));
                end
                if (q < T13) begin
                    n_lane[2] = lane_init(K13 - q, W_CNT'(4));
                end
            end
            MODE_WC2: begin
                n_lane[0] = lane_init(omq, W_CNT'(3));
            end
            MODE_WC4: begin
                n_lane[0] = lane_init(omq, W_CNT'(5));
                n_lane[1] = lane_init(q, W_CNT'(1));
            end
            MODE_WC6: begin
                n_lane[0] = lane_init(omq, W_CNT'(7));
                n_lane[1] = lane_init(q, W_CNT'(1));
                n_lane[2] = lane_init(q, W_CNT'(2));
            end
            default: begin
                n_lane = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane      <= n_lane;
            r_side.mode <= i_mode;
            r_side.q    <= q;
        end
    end

    assign o_lane = r_lane;
    assign o_side = r_side;

endmodule

@@ rtl/sphk_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphk_cell: one power step
// Each active lane takes r <= round(r * x) in Q.30 and passes on.
// ----------------------------------------------------------------------------
module sphk_cell (
    input  logic                                     i_clk,
    input  logic                                     i_en,
    input  sphk_pkg::t_lane [sphk_pkg::N_LANES-1:0]  i_lane,
    input  sphk_pkg::t_side                          i_side,
    output sphk_pkg::t_lane [sphk_pkg::N_LANES-1:0]  o_lane,
    output sphk_pkg::t_side                          o_side
);
    import sphk_pkg::*;

    localparam logic [2*W_Q-1:0] RND = (2*W_Q)'(1) << (IB - 1);

    logic [2*W_Q-1:0]    prod [N_LANES];
    t_lane [N_LANES-1:0] n_lane;
    t_lane [N_LANES-1:0] r_lane;
    t_side               r_side;

    always_comb begin
        n_lane = i_lane;
        for (int l = 0; l < N_LANES; l++) begin
            prod[l] = (2*W_Q)'(i_lane[l].r) * (2*W_Q)'(i_lane[l].x) + RND;
            if (i_lane[l].cnt != '0) begin
                n_lane[l].r   = prod[l][IB +: W_Q];
                n_lane[l].cnt = i_lane[l].cnt - W_CNT'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
            r_side <= i_side;
        end
    end

    assign o_lane = r_lane;
    assign o_side = r_side;

endmodule

@@ rtl/sphk_tail.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphk_tail: kernel assembly
// Wendland polynomial factor, final product and spline weighted sum.
// ----------------------------------------------------------------------------
module sphk_tail (
    input  logic                                     i_clk,
    input  logic [2:0]                               i_en,
    input  sphk_pkg::t_lane [sphk_pkg::N_LANES-1:0]  i_lane,
    input  sphk_pkg::t_side                          i_side,
    output logic signed [sphk_pkg::W_WT-1:0]         o_w
);
    import sphk_pkg::*;

    localparam int W_M  = W_Q - 1;
    localparam int W_MP = W_Q + 32;
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;   // ceil(2^33 / 3)

    localparam logic [W_POLY-1:0] P_ONE = W_POLY'(Q_ONE);
    localparam logic [W_POLY-1:0] C4    = W_POLY'(4);
    localparam logic [W_POLY-1:0] C6    = W_POLY'(6);
    localparam logic [W_POLY-1:0] C8    = W_POLY'(8);
    localparam logic [W_POLY-1:0] C25   = W_POLY'(25);
    localparam logic [W_POLY-1:0] C32   = W_POLY'(32);
    localparam logic [W_POLY-1:0] C35   = W_POLY'(35);

    localparam logic signed [W_SUM-1:0] S4  = W_SUM'(4);
    localparam logic signed [W_SUM-1:0] S5  = W_SUM'(5);
    localparam logic signed [W_SUM-1:0] S6  = W_SUM'(6);
    localparam logic signed [W_SUM-1:0] S10 = W_SUM'(10);
    localparam logic signed [W_SUM-1:0] S15 = W_SUM'(15);

    localparam int W_P3 = W_Q + W_POLY;
    localparam logic [W_P3-1:0] RND = W_P3'(1) << (IB - 1);

    // stage 1: q^2 / 3 by reciprocal
    logic [W_MP-1:0]            m_prod;
    logic [W_Q-1:0]             s1_r0, s1_r1, s1_r2;
    logic [W_M-1:0]             s1_m;
    t_side                      s1_side;

    // stage 2: polynomial factor and spline sum
    logic [W_Q-1:0]             rem_full;
    logic [W_POLY-1:0]          rem_add;
    logic [W_POLY-1:0]          n_poly;
    logic signed [W_SUM-1:0]    a0, a1, a2, n_sum;
    logic [W_Q-1:0]             s2_pw;
    logic [W_POLY-1:0]          s2_poly;
    logic signed [W_SUM-1:0]    s2_sum;
    logic [2:0]                 s2_mode;

    // stage 3: final product and selection
    logic [W_P3-1:0]            w_prod;
    logic signed [W_WT-1:0]     n_w;
    logic signed [W_WT-1:0]     s3_w;

    assign m_prod = W_MP'(i_lane[1].r) * W_MP'(RECIP3);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            s1_r0   <= i_lane[0].r;
            s1_r1   <= i_lane[1].r;
            s1_r2   <= i_lane[2].r;
            s1_m    <= m_prod[33 +: W_M];
            s1_side <= i_side;
        end
    end

    always_comb begin
        rem_full = s1_r1 - W_Q'(s1_m) * W_Q'(3);
        unique case (rem_full[1:0])
            2'd1:    rem_add = W_POLY'(12);
            2'd2:    rem_add = W_POLY'(23);
            default: rem_add = '0;
        endcase

        unique case (t_mode'(s1_side.mode))
            MODE_WC2: n_poly = P_ONE + W_POLY'(s1_side.q) * C4;
            MODE_WC4: n_poly = P_ONE + W_POLY'(s1_side.q) * C6 + W_POLY'(s1_m) * C35 + rem_add;
            MODE_WC6: n_poly = P_ONE + W_POLY'(s1_side.q) * C8 + W_POLY'(s1_r1) * C25
                               + W_POLY'(s1_r2) * C32;
            default:  n_poly = '0;
        endcase

        a0 = $signed(W_SUM'(s1_r0));
        a1 = $signed(W_SUM'(s1_r1));
        a2 = $signed(W_SUM'(s1_r2));
        unique case (t_mode'(s1_side.mode))
            MODE_CUBIC:   n_sum = a0 - S4 * a1;
            MODE_QUARTIC: n_sum = a0 - S5 * a1 + S10 * a2;
            MODE_QUINTIC: n_sum = a0 - S6 * a1 + S15 * a2;
            default:      n_sum = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            s2_pw   <= s1_r0;
            s2_poly <= n_poly;
            s2_sum  <= n_sum;
            s2_mode <= s1_side.mode;
        end
    end

    always_comb begin
        w_prod = W_P3'(s2_pw) * W_P3'(s2_poly) + RND;
        unique case (t_mode'(s2_mode))
            MODE_CUBIC, MODE_QUARTIC, MODE_QUINTIC: n_w = W_WT'(s2_sum);
            MODE_WC2, MODE_WC4, MODE_WC6:           n_w = $signed({1'b0, w_prod[IB +: W_WT-1]});
            default:                                n_w = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            s3_w <= n_w;
        end
    end

    assign o_w = s3_w;

endmodule
